// File: rtl/ptc_pkg.sv
// shared widths, codes, types and constants of the pressure/temperature compensation unit
package ptc_pkg;

  localparam int RAW_W      = 24;
  localparam int CAL_W      = 16;
  localparam int TEMP_W     = 19;
  localparam int PRES_W     = 32;
  localparam int CFG_IDX_W  = 3;

  // front datapath widths
  localparam int DT_W       = 25;
  localparam int PROD_W     = 42;
  localparam int DTSQ_W     = 2 * DT_W;
  localparam int T2_W       = 17;
  localparam int OFF_W      = 36;

  // scaling shifts
  localparam int C5_SHIFT   = 8;
  localparam int C2_SHIFT   = 17;
  localparam int C1_SHIFT   = 16;
  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 6;
  localparam int SENS_SHIFT = 7;
  localparam int T2_SHIFT   = 31;
  localparam int PMUL_SHIFT = 21;
  localparam int PRES_SHIFT = 15;

  // second-order correction factors
  localparam int OFF2_A_MUL  = 61;
  localparam int OFF2_A_SHR  = 4;
  localparam int OFF2_B_MUL  = 15;
  localparam int SENS2_A_SHL = 1;
  localparam int SENS2_B_SHL = 3;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  localparam cal_t CAL_RESET = '{
    c1: 16'd46372,
    c2: 16'd43981,
    c3: 16'd29059,
    c4: 16'd27842,
    c5: 16'd31553,
    c6: 16'd28165
  };

  // first-order results handed from front to back
  typedef struct packed {
    logic [RAW_W-1:0]         raw_pressure;
    logic signed [TEMP_W-1:0] temp1;
    logic [T2_W-1:0]          t2;
    logic signed [OFF_W-1:0]  off;
    logic signed [OFF_W-1:0]  sens;
    logic                     second;
    logic                     cold;
  } front_item_t;

endpackage

// File: rtl/ptc_intf.sv
// request, response and calibration write channels of the compensation unit
interface ptc_req_if import ptc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_rsp_if import ptc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;
  logic                     second_order_used;
  logic                     pressure_saturated;

  modport source (output valid, output temperature, output pressure,
                  output second_order_used, output pressure_saturated, input ready);
  modport sink   (input valid, input temperature, input pressure,
                  input second_order_used, input pressure_saturated, output ready);
endinterface

interface ptc_cfg_if import ptc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pressure_temperature_compensation_unit.sv
// top level of the second-order pressure/temperature compensation unit
//
// req_i carries one raw temperature (D2) and raw pressure (D1) reading pair per
// request; rsp_o returns the compensated temperature in 0.01 C, pressure in
// 0.01 mbar and the second-order and saturation flags, one response per request,
// in request order. cfg_i writes calibration words C1..C6 at indexes 0..5;
// other indexes are dropped. cfg_i is always ready; write it only while idle.
// Throughput is one request per cycle while nothing stalls. A response passes
// three front stages (dT, products, first-order terms), the four-entry queue,
// and six back stages (squares, corrections, partial products, sum, scaling,
// clamp and output register) after its request is accepted.
// The front stalls only when the queue is full; the back stalls only when the
// output register holds a response that rsp_o has not taken, so up to 13
// requests can be in flight while the receiver stalls.
// Reset empties every stage and the queue and loads the default calibration
// words; the unit accepts requests from the first cycle after reset.
module pressure_temperature_compensation_unit import ptc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptc_cfg_if.sink    cfg_i,
  ptc_req_if.sink    req_i,
  ptc_rsp_if.source  rsp_o
);

  cal_t        cal;
  logic        front_valid, front_ready;
  front_item_t front_item;
  logic        back_valid, back_ready;
  front_item_t back_item;

  ptc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cal_o  (cal)
  );

  ptc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .cal_i        (cal),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  ptc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_item_i   (front_item),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_item_o  (back_item)
  );

  ptc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .rsp          (rsp_o)
  );

endmodule

// File: rtl/ptc_cfg_regs.sv
// calibration word registers C1..C6
module ptc_cfg_regs import ptc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ptc_cfg_if.sink  cfg,
  output cal_t     cal_o
);

  cal_t cal_q;

  assign cfg.ready = 1'b1;
  assign cal_o     = cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= CAL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_idx_e'(cfg.index))
        CFG_C1: cal_q.c1 <= cfg.data;
        CFG_C2: cal_q.c2 <= cfg.data;
        CFG_C3: cal_q.c3 <= cfg.data;
        CFG_C4: cal_q.c4 <= cfg.data;
        CFG_C5: cal_q.c5 <= cfg.data;
        CFG_C6: cal_q.c6 <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ptc_front.sv
// front pipeline: dT, first-order temperature, offset, sensitivity and classification
module ptc_front import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptc_req_if.sink     req,
  input  cal_t        cal_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output front_item_t item_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic en1, en2, en3;

  assign en3       = !s3_valid_q || item_ready_i;
  assign en2       = !s2_valid_q || en3;
  assign en1       = !s1_valid_q || en2;
  assign req.ready = en1;

  // stage 1: dT
  logic signed [DT_W:0]   dt_full;
  logic signed [DT_W-1:0] s1_dt_d, s1_dt_q;
  logic [RAW_W-1:0]       s1_d1_q;

  assign dt_full = $signed({2'b00, req.raw_temperature})
                 - $signed({2'b00, cal_i.c5, {C5_SHIFT{1'b0}}});
  assign s1_dt_d = dt_full[DT_W-1:0];

  // stage 2: products of dT
  logic signed [PROD_W-1:0] dt_ext;
  logic signed [PROD_W-1:0] s2_pt_d, s2_po_d, s2_ps_d;
  logic signed [PROD_W-1:0] s2_pt_q, s2_po_q, s2_ps_q;
  logic signed [DTSQ_W-1:0] s2_sq_d, s2_sq_q;
  logic [RAW_W-1:0]         s2_d1_q;

  assign dt_ext  = PROD_W'(s1_dt_q);
  assign s2_pt_d = dt_ext * PROD_W'($signed({1'b0, cal_i.c6}));
  assign s2_po_d = dt_ext * PROD_W'($signed({1'b0, cal_i.c4}));
  assign s2_ps_d = dt_ext * PROD_W'($signed({1'b0, cal_i.c3}));
  assign s2_sq_d = DTSQ_W'(s1_dt_q) * DTSQ_W'(s1_dt_q);

  // stage 3: scale toward zero, add base terms, classify
  logic [PROD_W-1:0]        pt_adj, po_adj, ps_adj;
  logic signed [TEMP_W-1:0] temp1_d;
  logic signed [OFF_W-1:0]  off_d, sens_d;
  logic                     second_d;
  front_item_t              item_d, item_q;

  assign pt_adj = s2_pt_q + (s2_pt_q[PROD_W-1] ?
                  {{(PROD_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{1'b1}}} : '0);
  assign po_adj = s2_po_q + (s2_po_q[PROD_W-1] ?
                  {{(PROD_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{1'b1}}} : '0);
  assign ps_adj = s2_ps_q + (s2_ps_q[PROD_W-1] ?
                  {{(PROD_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{1'b1}}} : '0);

  assign temp1_d  = $signed(pt_adj[PROD_W-1:TEMP_SHIFT]) + TEMP_REF;
  assign off_d    = OFF_W'($signed(po_adj[PROD_W-1:OFF_SHIFT]))
                  + $signed({{(OFF_W-CAL_W-C2_SHIFT){1'b0}}, cal_i.c2, {C2_SHIFT{1'b0}}});
  assign sens_d   = OFF_W'($signed(ps_adj[PROD_W-1:SENS_SHIFT]))
                  + $signed({{(OFF_W-CAL_W-C1_SHIFT){1'b0}}, cal_i.c1, {C1_SHIFT{1'b0}}});
  assign second_d = temp1_d < TEMP_REF;

  always_comb begin
    item_d.raw_pressure = s2_d1_q;
    item_d.temp1        = temp1_d;
    // t2 only counts below 20 C
    item_d.t2           = second_d ? s2_sq_q[T2_SHIFT+T2_W-1:T2_SHIFT] : '0;
    item_d.off          = off_d;
    item_d.sens         = sens_d;
    item_d.second       = second_d;
    item_d.cold         = temp1_d < TEMP_COLD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= req.valid;
      if (en2) s2_valid_q <= s1_valid_q;
      if (en3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= req.raw_pressure;
    end
    if (en2) begin
      s2_pt_q <= s2_pt_d;
      s2_po_q <= s2_po_d;
      s2_ps_q <= s2_ps_d;
      s2_sq_q <= s2_sq_d;
      s2_d1_q <= s1_d1_q;
    end
    if (en3) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = s3_valid_q;
  assign item_o       = item_q;

endmodule

// File: rtl/ptc_fifo.sv
// short queue of first-order results between front and back
module ptc_fifo import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  front_item_t in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output front_item_t out_item_o
);

  front_item_t           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  push, pop;

  assign in_ready_o  = count_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) count_d = count_q + 1'b1;
    if (pop && !push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

  a_full_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("full queue with pointers apart");

endmodule

// File: rtl/ptc_back.sv
// back pipeline: second-order correction, pressure product, scaling and clamp
module ptc_back import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  front_item_t item_i,
  ptc_rsp_if.source   rsp
);

  localparam int SQ_W    = 34;
  localparam int OFF2_W  = 39;
  localparam int SENS2_W = 38;
  localparam int CORR_W  = 40;
  localparam int SPLIT_W = CORR_W / 2;
  localparam int PPLO_W  = RAW_W + SPLIT_W;
  localparam int PPHI_W  = RAW_W + 1 + CORR_W - SPLIT_W;
  localparam int PMUL_W  = RAW_W + 1 + CORR_W;
  localparam int Q1_W    = PMUL_W - PMUL_SHIFT;
  localparam int R_W     = Q1_W + 1;
  localparam int P_W     = R_W - PRES_SHIFT;

  localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
  localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic en1, en2, en3, en4, en5, en_out;

  assign en_out       = !out_valid_q || rsp.ready;
  assign en5          = !v5_q || en_out;
  assign en4          = !v4_q || en5;
  assign en3          = !v3_q || en4;
  assign en2          = !v2_q || en3;
  assign en1          = !v1_q || en2;
  assign item_ready_o = en1;

  // stage 1: squares of the temperature distances
  logic signed [TEMP_W-1:0]   a_dist, b_dist;
  logic signed [2*TEMP_W-1:0] a_sq, b_sq;
  logic [SQ_W-1:0]            asq_d, bsq_d, asq_q, bsq_q;
  front_item_t                b1_item_q;

  assign a_dist = item_i.temp1 - TEMP_REF;
  assign b_dist = item_i.temp1 - TEMP_COLD;
  assign a_sq   = (2*TEMP_W)'(a_dist) * (2*TEMP_W)'(a_dist);
  assign b_sq   = (2*TEMP_W)'(b_dist) * (2*TEMP_W)'(b_dist);
  assign asq_d  = item_i.second ? a_sq[SQ_W-1:0] : '0;
  assign bsq_d  = item_i.cold ? b_sq[SQ_W-1:0] : '0;

  // stage 2: corrected offset, sensitivity and temperature
  logic [SQ_W+6-1:0]          a61;
  logic [SQ_W+4-1:0]          b15;
  logic [OFF2_W-1:0]          off2;
  logic [SENS2_W-1:0]         sens2;
  logic signed [CORR_W-1:0]   offc_d, sensc_d, b2_offc_q, b2_sensc_q;
  logic signed [TEMP_W:0]     temp_full;
  logic signed [TEMP_W-1:0]   b2_temp_q;
  logic [RAW_W-1:0]           b2_d1_q;
  logic                       b2_second_q;

  assign a61   = (SQ_W+6)'(asq_q) * (SQ_W+6)'(OFF2_A_MUL);
  assign b15   = (SQ_W+4)'(bsq_q) * (SQ_W+4)'(OFF2_B_MUL);
  assign off2  = OFF2_W'(a61[SQ_W+5:OFF2_A_SHR]) + OFF2_W'(b15);
  assign sens2 = SENS2_W'({asq_q, {SENS2_A_SHL{1'b0}}})
               + SENS2_W'({bsq_q, {SENS2_B_SHL{1'b0}}});

  assign offc_d    = CORR_W'(b1_item_q.off) - $signed({{(CORR_W-OFF2_W){1'b0}}, off2});
  assign sensc_d   = CORR_W'(b1_item_q.sens) - $signed({{(CORR_W-SENS2_W){1'b0}}, sens2});
  assign temp_full = (TEMP_W+1)'(b1_item_q.temp1)
                   - $signed({{(TEMP_W+1-T2_W){1'b0}}, b1_item_q.t2});

  // stage 3: D1 times corrected sensitivity as two partial products
  logic [SPLIT_W-1:0]         sens_lo;
  logic signed [CORR_W-SPLIT_W-1:0] sens_hi;
  logic [PPLO_W-1:0]          pp_lo_d, pp_lo_q;
  logic signed [PPHI_W-1:0]   pp_hi_d, pp_hi_q;
  logic signed [CORR_W-1:0]   b3_offc_q;
  logic signed [TEMP_W-1:0]   b3_temp_q;
  logic                       b3_second_q;

  assign sens_lo = b2_sensc_q[SPLIT_W-1:0];
  assign sens_hi = $signed(b2_sensc_q[CORR_W-1:SPLIT_W]);
  assign pp_lo_d = PPLO_W'(b2_d1_q) * PPLO_W'(sens_lo);
  assign pp_hi_d = PPHI_W'($signed({1'b0, b2_d1_q})) * PPHI_W'(sens_hi);

  // stage 4: combine partial products
  logic signed [PMUL_W-1:0]   prod_d, b4_prod_q;
  logic signed [CORR_W-1:0]   b4_offc_q;
  logic signed [TEMP_W-1:0]   b4_temp_q;
  logic                       b4_second_q;

  assign prod_d = (PMUL_W'(pp_hi_q) <<< SPLIT_W)
                + $signed({{(PMUL_W-PPLO_W){1'b0}}, pp_lo_q});

  // stage 5: divide by 2^21 toward zero, subtract offset
  logic [PMUL_W-1:0]          prod_adj;
  logic signed [Q1_W-1:0]     q1;
  logic signed [R_W-1:0]      r_d, b5_r_q;
  logic signed [TEMP_W-1:0]   b5_temp_q;
  logic                       b5_second_q;

  assign prod_adj = b4_prod_q + (b4_prod_q[PMUL_W-1] ?
                    {{(PMUL_W-PMUL_SHIFT){1'b0}}, {PMUL_SHIFT{1'b1}}} : '0);
  assign q1       = $signed(prod_adj[PMUL_W-1:PMUL_SHIFT]);
  assign r_d      = R_W'(q1) - R_W'(b4_offc_q);

  // output stage: divide by 2^15 toward zero and clamp
  logic [R_W-1:0]             r_adj;
  logic signed [P_W-1:0]      p_val;
  logic signed [PRES_W:0]     p_ext;
  logic                       sat_hi, sat_lo;
  logic signed [PRES_W-1:0]   pres_d;
  logic signed [TEMP_W-1:0]   out_temp_q;
  logic signed [PRES_W-1:0]   out_pres_q;
  logic                       out_second_q, out_sat_q;

  assign r_adj  = b5_r_q + (b5_r_q[R_W-1] ?
                  {{(R_W-PRES_SHIFT){1'b0}}, {PRES_SHIFT{1'b1}}} : '0);
  assign p_val  = $signed(r_adj[R_W-1:PRES_SHIFT]);
  assign p_ext  = (PRES_W+1)'(p_val);
  assign sat_hi = p_ext > (PRES_W+1)'(PRES_MAX);
  assign sat_lo = p_ext < (PRES_W+1)'(PRES_MIN);

  always_comb begin
    priority if (sat_hi) pres_d = PRES_MAX;
    else if (sat_lo)     pres_d = PRES_MIN;
    else                 pres_d = p_ext[PRES_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= item_valid_i;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en4)    v4_q        <= v3_q;
      if (en5)    v5_q        <= v4_q;
      if (en_out) out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      asq_q     <= asq_d;
      bsq_q     <= bsq_d;
      b1_item_q <= item_i;
    end
    if (en2) begin
      b2_offc_q   <= offc_d;
      b2_sensc_q  <= sensc_d;
      b2_temp_q   <= temp_full[TEMP_W-1:0];
      b2_d1_q     <= b1_item_q.raw_pressure;
      b2_second_q <= b1_item_q.second;
    end
    if (en3) begin
      pp_lo_q     <= pp_lo_d;
      pp_hi_q     <= pp_hi_d;
      b3_offc_q   <= b2_offc_q;
      b3_temp_q   <= b2_temp_q;
      b3_second_q <= b2_second_q;
    end
    if (en4) begin
      b4_prod_q   <= prod_d;
      b4_offc_q   <= b3_offc_q;
      b4_temp_q   <= b3_temp_q;
      b4_second_q <= b3_second_q;
    end
    if (en5) begin
      b5_r_q      <= r_d;
      b5_temp_q   <= b4_temp_q;
      b5_second_q <= b4_second_q;
    end
    if (en_out) begin
      out_temp_q   <= b5_temp_q;
      out_pres_q   <= pres_d;
      out_second_q <= b5_second_q;
      out_sat_q    <= sat_hi || sat_lo;
    end
  end

  assign rsp.valid              = out_valid_q;
  assign rsp.temperature        = out_temp_q;
  assign rsp.pressure           = out_pres_q;
  assign rsp.second_order_used  = out_second_q;
  assign rsp.pressure_saturated = out_sat_q;

endmodule
